/* hw/rtl/ncs_pkg.sv */
// Shared types and constants for the NAND command cycle sequencer.
`default_nettype none

package ncs_pkg;

	// Bus cycle kinds.
	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_ADDR  = 2'd1;
	localparam logic [1:0] KIND_DELAY = 2'd2;
	localparam logic [1:0] KIND_POLL  = 2'd3;

	// Command codes that pick a follow-up sequence.
	localparam logic [8:0] CMD_READ0     = 9'h000;
	localparam logic [8:0] CMD_RNDOUT    = 9'h005;
	localparam logic [8:0] CMD_READSTART = 9'h030;
	localparam logic [8:0] CMD_READOOB   = 9'h050;
	localparam logic [8:0] CMD_STATUS    = 9'h070;
	localparam logic [8:0] CMD_RNDOUTST  = 9'h0e0;
	localparam logic [8:0] CMD_RESET     = 9'h0ff;
	localparam logic [8:0] CMD_PAGEPROG  = 9'h010;
	localparam logic [8:0] CMD_CACHEDPRG = 9'h015;
	localparam logic [8:0] CMD_ERASE1    = 9'h060;
	localparam logic [8:0] CMD_SEQIN     = 9'h080;
	localparam logic [8:0] CMD_RNDIN     = 9'h085;
	localparam logic [8:0] CMD_ERASE2    = 9'h0d0;
	localparam logic [8:0] CMD_NONE      = 9'h100;
	localparam logic [8:0] CMD_DLY_LO    = 9'h172;
	localparam logic [8:0] CMD_DLY_HI    = 9'h176;

	// Configuration register indexes.
	localparam logic REG_PAGE_DATA_BYTES = 1'b0;
	localparam logic REG_CHIP_DELAY_US   = 1'b1;

	localparam logic [12:0] PAGE_DATA_BYTES_RST = 13'd2048;
	localparam logic [9:0]  CHIP_DELAY_US_RST   = 10'd50;

	// Longest follow-up sequence (the normal read).
	localparam int FOLLOW_MAX = 5;
	// Command byte plus two column bytes.
	localparam int FIXED_SLOTS = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} slot_t;

endpackage

`default_nettype wire

/* hw/rtl/nand_command_cycle_sequencer.sv */
// Top level of the NAND command cycle sequencer.
// Each accepted request is expanded into its bus cycles (command byte, column bytes, page
// bytes, then a follow-up chosen by the command), and one cycle is delivered per clock
// unless the receiver stalls. A request yields from 1 to 8 + PAGE_ADDR_CYCLES bus cycles
// (11 with three page cycles) and holds the input side until its last one is handed on:
// the plan register drains one slot per unstalled clock into the output register, and the
// next request is taken on the clock at which the current one's final cycle moves into the
// output register. Configuration writes take effect at the next clock.
`default_nettype none

module nand_command_cycle_sequencer import ncs_pkg::*; #(
	parameter int PAGE_ADDR_CYCLES = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [8:0]  command_code,
	input  wire logic [12:0] column,
	input  wire logic        has_column,
	input  wire logic [23:0] page,
	input  wire logic        has_page,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       cycle_kind,
	output logic [7:0]       bus_byte,
	output logic [9:0]       delay_us,
	output logic             last
);

	localparam int MAX_SLOTS = FIXED_SLOTS + PAGE_ADDR_CYCLES + FOLLOW_MAX;
	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	logic [12:0] page_data_bytes_q;
	logic [9:0]  chip_delay_us_q;

	slot_t            plan_slots [MAX_SLOTS];
	logic [CNT_W-1:0] plan_count;
	slot_t            slots_s1 [MAX_SLOTS];
	logic [CNT_W-1:0] count_s1;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_q;

	logic  accept;
	logic  load;
	logic  final_slot;
	slot_t cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_data_bytes_q <= PAGE_DATA_BYTES_RST;
			chip_delay_us_q <= CHIP_DELAY_US_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAGE_DATA_BYTES: page_data_bytes_q <= cfg_data;
				REG_CHIP_DELAY_US: chip_delay_us_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	ncs_planner #(
		.PAGE_ADDR_CYCLES(PAGE_ADDR_CYCLES)
	) u_planner (
		.command_code(command_code),
		.column(column),
		.has_column(has_column),
		.page(page),
		.has_page(has_page),
		.page_data_bytes(page_data_bytes_q),
		.slots(plan_slots),
		.count(plan_count)
	);

	assign cur = slots_s1[idx_q];
	assign final_slot = ((CNT_W'(idx_q) + CNT_W'(1)) == count_s1);
	assign load = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !(load && final_slot);
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			idx_q <= '0;
		end else if (load) begin
			valid_s1 <= !final_slot;
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slots_s1 <= plan_slots;
			count_s1 <= plan_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cycle_kind <= cur.kind;
			bus_byte <= (cur.kind inside {KIND_CMD, KIND_ADDR}) ? cur.value : 8'h00;
			delay_us <= (cur.kind == KIND_DELAY) ? chip_delay_us_q : 10'd0;
			last <= final_slot;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ncs_planner.sv */
// Turns one request into its ordered list of bus cycles.
`default_nettype none

module ncs_planner import ncs_pkg::*; #(
	parameter int PAGE_ADDR_CYCLES = 3,
	parameter int MAX_SLOTS = FIXED_SLOTS + PAGE_ADDR_CYCLES + FOLLOW_MAX,
	parameter int IDX_W = $clog2(MAX_SLOTS),
	parameter int CNT_W = $clog2(MAX_SLOTS + 1)
) (
	input  wire logic [8:0]  command_code,
	input  wire logic [12:0] column,
	input  wire logic        has_column,
	input  wire logic [23:0] page,
	input  wire logic        has_page,
	input  wire logic [12:0] page_data_bytes,
	output slot_t            slots [MAX_SLOTS],
	output logic [CNT_W-1:0] count
);

	logic        oob;
	logic [8:0]  cmd;
	logic [13:0] col_sum;
	logic [12:0] half;
	logic [CNT_W-1:0] pos_page;
	logic [CNT_W-1:0] pos_follow;
	slot_t       follow [FOLLOW_MAX];
	logic [2:0]  follow_cnt;

	// An out-of-band read becomes a normal read; the offset applies only with a column.
	assign oob = (command_code == CMD_READOOB);
	assign cmd = oob ? CMD_READ0 : command_code;
	assign col_sum = {1'b0, column} + ((oob && has_column) ? {1'b0, page_data_bytes} : 14'd0);
	assign half = col_sum[13:1];

	assign pos_page = has_column ? CNT_W'(FIXED_SLOTS) : CNT_W'(1);
	assign pos_follow = pos_page + (has_page ? CNT_W'(PAGE_ADDR_CYCLES) : CNT_W'(0));
	assign count = pos_follow + CNT_W'(follow_cnt);

	always_comb begin
		for (int j = 0; j < FOLLOW_MAX; j++) begin
			follow[j] = '{kind: KIND_DELAY, value: 8'h00};
		end
		follow_cnt = 3'd1;
		case (cmd)
			CMD_PAGEPROG, CMD_CACHEDPRG, CMD_ERASE1, CMD_ERASE2,
			CMD_SEQIN, CMD_RNDIN, CMD_STATUS, CMD_NONE: begin
				follow_cnt = 3'd0;
			end
			CMD_RESET: begin
				follow[1] = '{kind: KIND_CMD, value: CMD_STATUS[7:0]};
				follow[2] = '{kind: KIND_POLL, value: 8'h00};
				follow_cnt = 3'd3;
			end
			CMD_RNDOUT: begin
				follow[0] = '{kind: KIND_CMD, value: CMD_RNDOUTST[7:0]};
				follow_cnt = 3'd1;
			end
			CMD_READ0: begin
				follow[0] = '{kind: KIND_CMD, value: CMD_READSTART[7:0]};
				follow[1] = '{kind: KIND_DELAY, value: 8'h00};
				follow[2] = '{kind: KIND_CMD, value: CMD_STATUS[7:0]};
				follow[3] = '{kind: KIND_POLL, value: 8'h00};
				follow[4] = '{kind: KIND_CMD, value: CMD_READ0[7:0]};
				follow_cnt = 3'd5;
			end
			default: begin
				// Extended delay codes and every unknown code get a single delay.
				follow_cnt = 3'd1;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < MAX_SLOTS; k++) begin
			slots[k] = '{kind: KIND_DELAY, value: 8'h00};
		end
		slots[0] = '{kind: KIND_CMD, value: cmd[7:0]};
		if (has_column) begin
			slots[1] = '{kind: KIND_ADDR, value: half[7:0]};
			slots[2] = '{kind: KIND_ADDR, value: {3'b000, half[12:8]}};
		end
		if (has_page) begin
			for (int i = 0; i < PAGE_ADDR_CYCLES; i++) begin
				slots[IDX_W'(pos_page + CNT_W'(i))] = '{kind: KIND_ADDR, value: page[8*i +: 8]};
			end
		end
		for (int j = 0; j < FOLLOW_MAX; j++) begin
			if (3'(j) < follow_cnt) begin
				slots[IDX_W'(pos_follow + CNT_W'(j))] = follow[j];
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ncs_checker.sv */
// Port-level checks for the NAND command cycle sequencer, bound to the top level.
`default_nettype none

module ncs_checker import ncs_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic        cfg_index,
	input wire logic [12:0] cfg_data,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [8:0]  command_code,
	input wire logic [12:0] column,
	input wire logic        has_column,
	input wire logic [23:0] page,
	input wire logic        has_page,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  cycle_kind,
	input wire logic [7:0]  bus_byte,
	input wire logic [9:0]  delay_us,
	input wire logic        last
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cycle_kind) && $stable(bus_byte)
			&& $stable(delay_us) && $stable(last))
		else $error("stalled result changed");

	// Every accepted item leads to a valid result on the output.
	a_item_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("accepted item produced no result");

	// Delay and poll cycles drive no bus byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cycle_kind == KIND_DELAY || cycle_kind == KIND_POLL) |-> bus_byte == 8'h00)
		else $error("bus byte on a delay or poll cycle");

	// Only delay cycles carry a wait length.
	a_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cycle_kind != KIND_DELAY |-> delay_us == 10'd0)
		else $error("wait length on a non-delay cycle");

endmodule

bind nand_command_cycle_sequencer ncs_checker u_ncs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_we(cfg_we),
	.cfg_index(cfg_index),
	.cfg_data(cfg_data),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.command_code(command_code),
	.column(column),
	.has_column(has_column),
	.page(page),
	.has_page(has_page),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.cycle_kind(cycle_kind),
	.bus_byte(bus_byte),
	.delay_us(delay_us),
	.last(last)
);

`default_nettype wire

/* sim/ncs_cycle_checker.sv */
// Checker for the NAND command cycle sequencer: predicts the bus cycles of each request and compares them.
module ncs_cycle_checker import ncs_pkg::*; #(
	parameter int PAGE_ADDR_CYCLES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [8:0]  command_code,
	input  logic [12:0] column,
	input  logic        has_column,
	input  logic [23:0] page,
	input  logic        has_page,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  cycle_kind,
	input  logic [7:0]  bus_byte,
	input  logic [9:0]  delay_us,
	input  logic        last,
	output int          mismatch_count,
	output int          cycles_pending
);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] bus_val;
		logic [9:0] delay_val;
		logic       final_flag;
	} bus_cycle_t;

	bus_cycle_t  expected_cycles[$];
	bus_cycle_t  plan[0:10];
	int          plan_len;
	logic [12:0] page_data_bytes_q;
	logic [9:0]  chip_delay_q;

	task plan_add(input logic [1:0] kind, input logic [7:0] val);
		plan[plan_len] = {kind,
			(kind == KIND_CMD || kind == KIND_ADDR) ? val : 8'd0,
			(kind == KIND_DELAY) ? chip_delay_q : 10'd0,
			1'b0};
		plan_len++;
	endtask

	task plan_bus_cycles(input logic [8:0] cmd_in, input logic [12:0] col_in,
		input logic col_on, input logic [23:0] pg, input logic pg_on);
		logic [8:0]  cmd;
		logic [13:0] col_sum;
		logic [12:0] half;
		logic [23:0] shifted;
		bus_cycle_t  cyc;
		int          i;
		cmd = cmd_in;
		col_sum = {1'b0, col_in};
		// An out-of-band read becomes a normal read; the offset only applies with a column.
		if (cmd == CMD_READOOB) begin
			if (col_on)
				col_sum = col_sum + {1'b0, page_data_bytes_q};
			cmd = CMD_READ0;
		end
		plan_len = 0;
		plan_add(KIND_CMD, cmd[7:0]);
		if (col_on) begin
			half = col_sum[13:1];
			plan_add(KIND_ADDR, half[7:0]);
			plan_add(KIND_ADDR, {3'b000, half[12:8]});
		end
		if (pg_on) begin
			for (i = 0; i < PAGE_ADDR_CYCLES && i < 3; i++) begin
				shifted = pg >> (8 * i);
				plan_add(KIND_ADDR, shifted[7:0]);
			end
		end
		// The follow-up is chosen by the full nine-bit code.
		case (cmd)
			CMD_PAGEPROG, CMD_CACHEDPRG, CMD_ERASE1, CMD_ERASE2,
			CMD_SEQIN, CMD_RNDIN, CMD_STATUS, CMD_NONE: ;
			CMD_RESET: begin
				plan_add(KIND_DELAY, 8'd0);
				plan_add(KIND_CMD, CMD_STATUS[7:0]);
				plan_add(KIND_POLL, 8'd0);
			end
			CMD_RNDOUT: plan_add(KIND_CMD, CMD_RNDOUTST[7:0]);
			CMD_READ0: begin
				plan_add(KIND_CMD, CMD_READSTART[7:0]);
				plan_add(KIND_DELAY, 8'd0);
				plan_add(KIND_CMD, CMD_STATUS[7:0]);
				plan_add(KIND_POLL, 8'd0);
				plan_add(KIND_CMD, CMD_READ0[7:0]);
			end
			// The delay-command range gets the same single delay as unknown codes.
			default: plan_add(KIND_DELAY, 8'd0);
		endcase
		for (i = 0; i < plan_len; i++) begin
			cyc = plan[i];
			cyc.final_flag = (i == plan_len - 1);
			expected_cycles.push_back(cyc);
		end
	endtask

	task check_cycle();
		bus_cycle_t got;
		bus_cycle_t want;
		got = {cycle_kind, bus_byte, delay_us, last};
		if (expected_cycles.size() == 0) begin
			if (mismatch_count < 10)
				$display("unexpected bus cycle: kind %0d byte %02h delay %0d last %0b",
					got.kind, got.bus_val, got.delay_val, got.final_flag);
			mismatch_count++;
		end else begin
			want = expected_cycles.pop_front();
			if (got !== want) begin
				if (mismatch_count < 10)
					$display("bus cycle mismatch: expected kind %0d byte %02h delay %0d last %0b, got kind %0d byte %02h delay %0d last %0b",
						want.kind, want.bus_val, want.delay_val, want.final_flag,
						got.kind, got.bus_val, got.delay_val, got.final_flag);
				mismatch_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_data_bytes_q = PAGE_DATA_BYTES_RST;
			chip_delay_q = CHIP_DELAY_US_RST;
			mismatch_count = 0;
			cycles_pending = 0;
		end else begin
			if (in_valid && !in_stall)
				plan_bus_cycles(command_code, column, has_column, page, has_page);
			if (out_valid && !out_stall)
				check_cycle();
			// Writes only come while idle, so updating after prediction is safe.
			if (cfg_we) begin
				if (cfg_index == REG_PAGE_DATA_BYTES)
					page_data_bytes_q = cfg_data;
				else
					chip_delay_q = cfg_data[9:0];
			end
			cycles_pending = expected_cycles.size();
		end
	end

endmodule

/* sim/testbench.sv */
// Top of the NAND command cycle sequencer testbench: clock, reset, stimulus and verdict.
module testbench;
	import ncs_pkg::*;

	localparam int PAGE_CYCLES = 3;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [12:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [8:0]  command_code;
	logic [12:0] column;
	logic        has_column;
	logic [23:0] page;
	logic        has_page;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  cycle_kind;
	logic [7:0]  bus_byte;
	logic [9:0]  delay_us;
	logic        last;
	int          mismatch_count;
	int          cycles_pending;
	int          idle_cycles;
	logic        quiet;

	nand_command_cycle_sequencer #(.PAGE_ADDR_CYCLES(PAGE_CYCLES)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command_code(command_code), .column(column), .has_column(has_column),
		.page(page), .has_page(has_page),
		.out_valid(out_valid), .out_stall(out_stall),
		.cycle_kind(cycle_kind), .bus_byte(bus_byte), .delay_us(delay_us), .last(last)
	);

	ncs_cycle_checker #(.PAGE_ADDR_CYCLES(PAGE_CYCLES)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command_code(command_code), .column(column), .has_column(has_column),
		.page(page), .has_page(has_page),
		.out_valid(out_valid), .out_stall(out_stall),
		.cycle_kind(cycle_kind), .bus_byte(bus_byte), .delay_us(delay_us), .last(last),
		.mismatch_count(mismatch_count), .cycles_pending(cycles_pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The run is cut short when nothing moves on any port for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// Unless quiet is set, the receiver holds off each bus cycle for a random number of clocks.
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 3);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task send_request(input logic [8:0] cmd, input logic [12:0] col, input logic col_on,
		input logic [23:0] pg, input logic pg_on);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command_code <= cmd;
		column <= col;
		has_column <= col_on;
		page <= pg;
		has_page <= pg_on;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	function automatic logic [8:0] pick_command();
		case ($urandom_range(0, 21))
			0, 1, 2:  return CMD_READ0;
			3, 4, 5:  return CMD_READOOB;
			6:        return CMD_RNDOUT;
			7, 8:     return CMD_RESET;
			9:        return CMD_PAGEPROG;
			10:       return CMD_CACHEDPRG;
			11:       return CMD_ERASE1;
			12:       return CMD_ERASE2;
			13:       return CMD_SEQIN;
			14:       return CMD_RNDIN;
			15:       return CMD_STATUS;
			16:       return CMD_NONE;
			17:       return 9'($urandom_range(CMD_DLY_LO, CMD_DLY_HI));
			18:       return {1'b1, CMD_RESET[7:0]};
			19:       return 9'($urandom_range(0, 255));
			default:  return 9'($urandom_range(0, 511));
		endcase
	endfunction

	task random_request();
		logic [12:0] col;
		logic [23:0] pg;
		case ($urandom_range(0, 7))
			0:       col = 13'h1fff;
			1:       col = 13'h0000;
			default: col = 13'($urandom_range(0, 8191));
		endcase
		pg = 24'($urandom);
		send_request(pick_command(), col, 1'($urandom_range(0, 3) != 0), pg,
			1'($urandom_range(0, 3) != 0));
	endtask

	// Returns once every predicted cycle has come out and the block has settled.
	task wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (cycles_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_reg(input logic idx, input logic [12:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task run_phase(input logic [12:0] data_bytes, input logic [12:0] delay_val, input int count);
		int i;
		wait_idle();
		write_reg(REG_PAGE_DATA_BYTES, data_bytes);
		write_reg(REG_CHIP_DELAY_US, delay_val);
		for (i = 0; i < count; i++) begin
			// Idling is switched off for some stretches of items.
			if (i % 24 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			random_request();
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PAGE_DATA_BYTES;
		cfg_data = '0;
		in_valid = 1'b0;
		command_code = CMD_READ0;
		column = '0;
		has_column = 1'b0;
		page = '0;
		has_page = 1'b0;
		quiet = 1'b0;
		idle_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset register values.
		send_request(CMD_READ0, 13'h0000, 1'b1, 24'h000000, 1'b1);
		send_request(CMD_READ0, 13'h1fff, 1'b1, 24'hffffff, 1'b1);
		send_request(CMD_READOOB, 13'h1fff, 1'b1, 24'h123456, 1'b1);
		send_request(CMD_READOOB, 13'h0064, 1'b0, 24'h000000, 1'b1);
		send_request(CMD_READOOB, 13'h0000, 1'b1, 24'h000000, 1'b0);
		send_request(CMD_RNDOUT, 13'h04d2, 1'b1, 24'h000000, 1'b0);
		send_request(CMD_RESET, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request({1'b1, CMD_RESET[7:0]}, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request(CMD_NONE, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request(CMD_DLY_LO, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request(CMD_DLY_HI, 13'h0005, 1'b1, 24'habcdef, 1'b1);
		send_request(CMD_PAGEPROG, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request(CMD_CACHEDPRG, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request(CMD_ERASE1, 13'h0000, 1'b0, 24'hffffff, 1'b1);
		send_request(CMD_ERASE2, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request(CMD_SEQIN, 13'h1fff, 1'b1, 24'h800001, 1'b1);
		send_request(CMD_RNDIN, 13'h002a, 1'b1, 24'h000000, 1'b0);
		send_request(CMD_STATUS, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request(CMD_READSTART, 13'h0000, 1'b0, 24'h000000, 1'b0);
		send_request(CMD_RNDOUTST, 13'h0000, 1'b0, 24'h000000, 1'b0);
		// An extended code whose low byte is the out-of-band read is not converted.
		send_request({1'b1, CMD_READOOB[7:0]}, 13'h0100, 1'b1, 24'h000000, 1'b0);
		send_request(CMD_READ0, 13'h0000, 1'b0, 24'h5a5a5a, 1'b1);
		for (i = 0; i < 60; i++)
			random_request();

		run_phase(13'd512, 13'd0, 76);
		run_phase(13'd4096, 13'd1023, 76);
		// Both registers at their full width; the delay keeps only ten bits.
		run_phase(13'h1fff, 13'h1fff, 76);
		run_phase(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)), 76);
		run_phase(13'd1536, 13'd1, 76);

		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && cycles_pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
